### src/tsmbq_pkg.sv
// shared types, constants and helpers for the tcp send message boundary queue
// no dependencies; used by tsmbq_out_reg, tsmbq_chk and the top level in src
package tsmbq_pkg;

	// ring geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// field widths
	localparam int SEQ_W     = 32;
	localparam int TAG_W     = 16;
	localparam int LEN_W     = 16;
	localparam int ENTRY_W   = SEQ_W + TAG_W;
	localparam int IN_DATA_W = 120;
	localparam int OUT_DATA_W = 112;
	localparam int OUT_USER_W = 3;

	// configuration address space
	localparam int PADDR_W = 3;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_QUERY   = 2'd1,
		OP_DISCARD = 2'd2,
		OP_UNUSED  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RSVD  = 2'd3
	} status_t;

	// one result request as it leaves the control logic
	typedef struct packed {
		logic [SEQ_W-1:0] buffer_start;
		logic [SEQ_W-1:0] buffer_end;
		logic [SEQ_W-1:0] boundary_seq;
		logic [TAG_W-1:0] boundary_tag;
		logic             boundary_valid;
		logic             last_result;
		status_t          status;
	} result_t;

	// modulo 2^32 compare: a is at or before b
	function automatic logic seq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return (d == '0) || d[SEQ_W-1];
	endfunction

	// ring index step with wrap at the queue depth
	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
		return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

endpackage

### src/tsmbq_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module tsmbq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/tsmbq_out_reg.sv
// output register for result requests on the master stream side
// depends on tsmbq_pkg
module tsmbq_out_reg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  tsmbq_pkg::result_t               res,
	output logic                             free,
	output logic                             tvalid,
	input  logic                             tready,
	output logic [tsmbq_pkg::OUT_DATA_W-1:0] tdata,
	output logic [tsmbq_pkg::OUT_USER_W-1:0] tuser,
	output logic                             tlast
);

	logic               valid_q;
	tsmbq_pkg::result_t res_q;

	// slot can take a request when empty or being drained this cycle
	assign free = !valid_q || tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign tvalid = valid_q;
	assign tdata  = {res_q.boundary_tag, res_q.boundary_seq, res_q.buffer_end, res_q.buffer_start};
	assign tuser  = {res_q.status, res_q.boundary_valid};
	assign tlast  = res_q.last_result;

endmodule

### src/tcp_send_message_boundary_queue_unit.sv
// top level of the tcp send message boundary queue: control sequencer,
// boundary ring memory and output register
// depends on tsmbq_pkg, tsmbq_ram, tsmbq_out_reg
//
// Usage
//   s_axis carries one operation per request: enqueue a message, query the
//   message ends inside a segment, or discard acknowledged data.
//   m_axis returns the results; tlast marks the final result of a request.
//   An APB port holds initial_sequence at address 0; writing it sets buffer
//   start and end to the value and empties the ring. Write it only while idle.
// Request handling
//   Enqueue, unused and out-of-range requests: one result, registered at the
//   accepting edge; the next request can be taken in the following cycle if
//   m_axis_tready is high. An in-range query or discard then walks the ring,
//   stepping past each entry skipped, included or popped; its final result
//   shows the cycle after the walk ends.
//   The walk is paced by the single read port of the boundary ring, read one
//   entry per cycle while the sequencer walks it and no query result is held.
// Reset
//   arst_n clears the pointers, the count and both sequence numbers to zero;
//   ring contents are left as they are.
// Back-pressure
//   A held result stalls a query walk; s_axis_tready stays low until the
//   current request has handed its final result to the output register.
module tcp_send_message_boundary_queue_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// s_axis_tdata from bit 0: opcode[1:0], message_length[17:2],
	// message_tag[33:18], segment_start[65:34], segment_length[81:66],
	// acked_seq[113:82], zero fill [119:114]
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tsmbq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// m_axis_tdata from bit 0: buffer_start[31:0], buffer_end[63:32],
	// boundary_seq[95:64], boundary_tag[111:96]
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [tsmbq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// m_axis_tuser from bit 0: boundary_valid[0], status[2:1]
	output logic [tsmbq_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                             m_axis_tlast,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tsmbq_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_QUERY,
		S_DISCARD
	} state_t;

	state_t                              state_q;
	logic [tsmbq_pkg::SEQ_W-1:0]         cfg_q;
	logic [tsmbq_pkg::SEQ_W-1:0]         start_q;
	logic [tsmbq_pkg::SEQ_W-1:0]         end_q;
	logic [tsmbq_pkg::IDX_W-1:0]         head_q;
	logic [tsmbq_pkg::IDX_W-1:0]         tail_q;
	logic [tsmbq_pkg::CNT_W-1:0]         count_q;
	logic [tsmbq_pkg::IDX_W-1:0]         ptr_q;
	logic [tsmbq_pkg::CNT_W-1:0]         rem_q;
	logic                                skip_q;
	logic [tsmbq_pkg::SEQ_W-1:0]         lo_q;
	logic [tsmbq_pkg::SEQ_W-1:0]         hi_q;
	logic                                pend_v_q;
	logic [tsmbq_pkg::SEQ_W-1:0]         pend_seq_q;
	logic [tsmbq_pkg::TAG_W-1:0]         pend_tag_q;

	// input field unpacking
	tsmbq_pkg::opcode_t                  op;
	logic [tsmbq_pkg::LEN_W-1:0]         msg_len;
	logic [tsmbq_pkg::TAG_W-1:0]         msg_tag;
	logic [tsmbq_pkg::SEQ_W-1:0]         seg_start;
	logic [tsmbq_pkg::LEN_W-1:0]         seg_len;
	logic [tsmbq_pkg::SEQ_W-1:0]         acked;

	assign op        = tsmbq_pkg::opcode_t'(s_axis_tdata[1:0]);
	assign msg_len   = s_axis_tdata[17:2];
	assign msg_tag   = s_axis_tdata[33:18];
	assign seg_start = s_axis_tdata[65:34];
	assign seg_len   = s_axis_tdata[81:66];
	assign acked     = s_axis_tdata[113:82];

	logic                                free;
	logic                                acc;
	logic                                push;
	tsmbq_pkg::result_t                  res;
	logic                                adv;
	logic                                take;
	logic                                done;
	logic                                ram_we;
	logic [tsmbq_pkg::IDX_W-1:0]         ptr_inc;
	logic [tsmbq_pkg::IDX_W-1:0]         rd_addr;
	logic [tsmbq_pkg::ENTRY_W-1:0]       rd_data;
	logic [tsmbq_pkg::SEQ_W-1:0]         e_seq;
	logic [tsmbq_pkg::TAG_W-1:0]         e_tag;
	logic [tsmbq_pkg::SEQ_W-1:0]         q_to;
	logic [tsmbq_pkg::SEQ_W-1:0]         new_end;
	logic                                q_ok;
	logic                                d_ok;
	logic                                full;
	logic                                cfg_we;

	assign e_seq   = rd_data[tsmbq_pkg::SEQ_W-1:0];
	assign e_tag   = rd_data[tsmbq_pkg::ENTRY_W-1:tsmbq_pkg::SEQ_W];
	assign ptr_inc = tsmbq_pkg::idx_inc(ptr_q);
	assign q_to    = seg_start + tsmbq_pkg::SEQ_W'(seg_len);
	assign new_end = end_q + tsmbq_pkg::SEQ_W'(msg_len);
	assign q_ok    = tsmbq_pkg::seq_le(start_q, seg_start) && tsmbq_pkg::seq_le(q_to, end_q);
	assign d_ok    = tsmbq_pkg::seq_le(start_q, acked) && tsmbq_pkg::seq_le(acked, end_q);
	assign full    = (count_q == tsmbq_pkg::CNT_W'(tsmbq_pkg::QUEUE_DEPTH));

	assign s_axis_tready = (state_q == S_IDLE) && free;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign ram_we        = acc && (op == tsmbq_pkg::OP_ENQUEUE) && !full;

	// configuration port
	assign pready = 1'b1;
	assign prdata = cfg_q;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

	// sequencer decisions: result requests, ring walk, pending entry capture
	always_comb begin
		push = 1'b0;
		adv  = 1'b0;
		take = 1'b0;
		done = 1'b0;
		res  = '{buffer_start: start_q, buffer_end: end_q, boundary_seq: '0,
			boundary_tag: '0, boundary_valid: 1'b0, last_result: 1'b1,
			status: tsmbq_pkg::STAT_OK};
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (op)
						tsmbq_pkg::OP_ENQUEUE: begin
							push = 1'b1;
							if (full) begin
								res.status = tsmbq_pkg::STAT_FULL;
							end else begin
								res.buffer_end = new_end;
							end
						end
						tsmbq_pkg::OP_QUERY: begin
							if (!q_ok) begin
								push       = 1'b1;
								res.status = tsmbq_pkg::STAT_RANGE;
							end
						end
						tsmbq_pkg::OP_DISCARD: begin
							if (!d_ok) begin
								push       = 1'b1;
								res.status = tsmbq_pkg::STAT_RANGE;
							end
						end
						default: begin
							push = 1'b1;
						end
					endcase
				end
			end
			S_QUERY: begin
				if (rem_q == '0) begin
					done = 1'b1;
				end else if (skip_q && tsmbq_pkg::seq_le(e_seq, lo_q)) begin
					adv = 1'b1;
				end else if (tsmbq_pkg::seq_le(e_seq, hi_q)) begin
					// earlier held entry goes out as a non-final result
					if (!pend_v_q) begin
						take = 1'b1;
						adv  = 1'b1;
					end else if (free) begin
						push               = 1'b1;
						take               = 1'b1;
						adv                = 1'b1;
						res.boundary_seq   = pend_seq_q;
						res.boundary_tag   = pend_tag_q;
						res.boundary_valid = 1'b1;
						res.last_result    = 1'b0;
					end
				end else begin
					done = 1'b1;
				end
				if (done && free) begin
					push = 1'b1;
					if (pend_v_q) begin
						res.boundary_seq   = pend_seq_q;
						res.boundary_tag   = pend_tag_q;
						res.boundary_valid = 1'b1;
					end
				end
			end
			S_DISCARD: begin
				if ((rem_q != '0) && tsmbq_pkg::seq_le(e_seq, lo_q)) begin
					adv = 1'b1;
				end else begin
					done = 1'b1;
					push = free;
				end
			end
			default: begin
			end
		endcase
	end

	// ring read address: next entry when walking, head while idle, else hold
	always_comb begin
		if (adv) begin
			rd_addr = ptr_inc;
		end else if (state_q == S_IDLE) begin
			rd_addr = head_q;
		end else begin
			rd_addr = ptr_q;
		end
	end

	// state and sequence registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cfg_q    <= '0;
			start_q  <= '0;
			end_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			ptr_q    <= '0;
			rem_q    <= '0;
			skip_q   <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						ptr_q    <= head_q;
						rem_q    <= count_q;
						skip_q   <= 1'b1;
						pend_v_q <= 1'b0;
						unique case (op)
							tsmbq_pkg::OP_ENQUEUE: begin
								if (!full) begin
									end_q   <= new_end;
									tail_q  <= tsmbq_pkg::idx_inc(tail_q);
									count_q <= count_q + 1'b1;
								end
							end
							tsmbq_pkg::OP_QUERY: begin
								if (q_ok) begin
									state_q <= S_QUERY;
								end
							end
							tsmbq_pkg::OP_DISCARD: begin
								if (d_ok) begin
									start_q <= acked;
									state_q <= S_DISCARD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_QUERY: begin
					if (!adv && !done) begin
						skip_q <= skip_q;
					end else if (!adv || !(skip_q && tsmbq_pkg::seq_le(e_seq, lo_q))) begin
						skip_q <= 1'b0;
					end
					if (take) begin
						pend_v_q <= 1'b1;
					end
					if (adv) begin
						ptr_q <= ptr_inc;
						rem_q <= rem_q - 1'b1;
					end
					if (done && free) begin
						state_q <= S_IDLE;
					end
				end
				S_DISCARD: begin
					if (adv) begin
						ptr_q   <= ptr_inc;
						rem_q   <= rem_q - 1'b1;
						head_q  <= ptr_inc;
						count_q <= count_q - 1'b1;
					end else if (free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// register write restarts the buffer
			if (cfg_we) begin
				cfg_q   <= pwdata;
				start_q <= pwdata;
				end_q   <= pwdata;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
		end
	end

	// query and discard bounds and held entry, no reset
	always_ff @(posedge clk) begin
		if (acc) begin
			lo_q <= (op == tsmbq_pkg::OP_DISCARD) ? acked : seg_start;
			hi_q <= q_to;
		end
		if (take) begin
			pend_seq_q <= e_seq;
			pend_tag_q <= e_tag;
		end
	end

	tsmbq_ram #(
		.DEPTH(tsmbq_pkg::QUEUE_DEPTH),
		.WIDTH(tsmbq_pkg::ENTRY_W)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(tail_q),
		.wdata({msg_tag, new_end}),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	tsmbq_out_reg u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.res   (res),
		.free  (free),
		.tvalid(m_axis_tvalid),
		.tready(m_axis_tready),
		.tdata (m_axis_tdata),
		.tuser (m_axis_tuser),
		.tlast (m_axis_tlast)
	);

endmodule

### src/tsmbq_chk.sv
// port-level checker for the tcp send message boundary queue, with its bind
// depends on tsmbq_pkg and tcp_send_message_boundary_queue_unit
module tsmbq_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [tsmbq_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input logic                             m_axis_tlast
);

	// a held result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// a new request is taken only when the output slot can take its result
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tready)
		else $error("request taken with output slot blocked");

	// error results carry no boundary and close the request
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[2:1] != tsmbq_pkg::STAT_OK)
		|-> m_axis_tlast && !m_axis_tuser[0])
		else $error("error result not final or carries a boundary");

	// results without a boundary are always final
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("empty result not final");

	// reserved status never shows
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[2:1] != tsmbq_pkg::STAT_RSVD)
		else $error("reserved status code");

endmodule

bind tcp_send_message_boundary_queue_unit tsmbq_chk u_tsmbq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);

### tb/sv/tsmbq_boundary_checker.sv
// checker for the tcp send message boundary queue: tracks buffer start, end and the
// boundary ring from accepted requests and compares each result taken from m_axis
// depends on tsmbq_pkg
module tsmbq_boundary_checker
	import tsmbq_pkg::*;
#(
	parameter logic [PADDR_W-1:0] INIT_SEQ_ADDR = '0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic [OUT_USER_W-1:0] m_axis_tuser,
	input  logic                  m_axis_tlast,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [31:0]           pwdata,
	input  logic                  pready,
	output int unsigned           bad_results,
	output int unsigned           owed_count,
	output logic [SEQ_W-1:0]      view_start,
	output logic [SEQ_W-1:0]      view_end
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_REPORTS = 10;
	// owed results never exceed one full query plus a waiting result
	localparam int unsigned OWED_DEPTH  = 256;

	// buffer window and boundary ring as the block should hold them
	logic [SEQ_W-1:0] buf_start = '0;
	logic [SEQ_W-1:0] buf_end = '0;
	logic [SEQ_W-1:0] ring_end [QUEUE_DEPTH];
	logic [TAG_W-1:0] ring_tag [QUEUE_DEPTH];
	int               head = 0;
	int               count = 0;
	int unsigned      mismatches = 0;
	result_t          owed_results [OWED_DEPTH];
	int unsigned      owed_wr = 0;
	int unsigned      owed_rd = 0;

	// a is at or before b in modulo 2^32 sequence space
	function automatic logic seq_not_after(input logic [SEQ_W-1:0] a,
			input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] diff;
		diff = a - b;
		return (diff == '0) || diff[SEQ_W-1];
	endfunction

	// single result carrying no boundary
	function automatic result_t plain_result(input status_t st);
		return '{buffer_start: buf_start, buffer_end: buf_end, boundary_seq: '0,
			boundary_tag: '0, boundary_valid: 1'b0, last_result: 1'b1, status: st};
	endfunction

	function automatic string describe(input result_t r);
		return $sformatf("start %h end %h seq %h tag %h valid %b last %b status %s",
			r.buffer_start, r.buffer_end, r.boundary_seq, r.boundary_tag,
			r.boundary_valid, r.last_result, r.status.name());
	endfunction

	// append one expected result at the tail of the owed list
	task automatic owe_result(input result_t r);
		owed_results[owed_wr % OWED_DEPTH] = r;
		owed_wr++;
	endtask

	task automatic restart_buffer(input logic [SEQ_W-1:0] seq);
		buf_start = seq;
		buf_end   = seq;
		head      = 0;
		count     = 0;
	endtask

	// apply one request to the window and ring, queue the results it owes
	task automatic step_boundary_queue(input logic [IN_DATA_W-1:0] req);
		opcode_t          op;
		logic [LEN_W-1:0] msg_len;
		logic [TAG_W-1:0] msg_tag;
		logic [LEN_W-1:0] seg_len;
		logic [SEQ_W-1:0] seg_start;
		logic [SEQ_W-1:0] seg_to;
		logic [SEQ_W-1:0] acked;
		int               first;
		int               stop;
		int               slot;
		int               k;
		op        = opcode_t'(req[1:0]);
		msg_len   = req[17:2];
		msg_tag   = req[33:18];
		seg_start = req[65:34];
		seg_len   = req[81:66];
		acked     = req[113:82];
		seg_to    = seg_start + SEQ_W'(seg_len);
		case (op)
			OP_ENQUEUE: begin
				if (count == QUEUE_DEPTH) begin
					owe_result(plain_result(STAT_FULL));
				end else begin
					buf_end = buf_end + SEQ_W'(msg_len);
					slot = (head + count) % QUEUE_DEPTH;
					ring_end[slot] = buf_end;
					ring_tag[slot] = msg_tag;
					count++;
					owe_result(plain_result(STAT_OK));
				end
			end
			OP_QUERY: begin
				if (!(seq_not_after(buf_start, seg_start) && seq_not_after(seg_to, buf_end))) begin
					owe_result(plain_result(STAT_RANGE));
				end else begin
					// skip messages already ended by the segment start
					first = 0;
					while (first < count &&
							seq_not_after(ring_end[(head + first) % QUEUE_DEPTH], seg_start))
						first++;
					// then every message ending inside the segment
					stop = first;
					while (stop < count &&
							seq_not_after(ring_end[(head + stop) % QUEUE_DEPTH], seg_to))
						stop++;
					if (stop == first)
						owe_result(plain_result(STAT_OK));
					for (k = first; k < stop; k++) begin
						slot = (head + k) % QUEUE_DEPTH;
						owe_result('{buffer_start: buf_start, buffer_end: buf_end,
							boundary_seq: ring_end[slot], boundary_tag: ring_tag[slot],
							boundary_valid: 1'b1, last_result: (k == stop - 1),
							status: STAT_OK});
					end
				end
			end
			OP_DISCARD: begin
				if (!(seq_not_after(buf_start, acked) && seq_not_after(acked, buf_end))) begin
					owe_result(plain_result(STAT_RANGE));
				end else begin
					buf_start = acked;
					// pop acknowledged messages from the oldest side
					while (count > 0 && seq_not_after(ring_end[head], acked)) begin
						head = (head + 1) % QUEUE_DEPTH;
						count--;
					end
					owe_result(plain_result(STAT_OK));
				end
			end
			default: begin
				owe_result(plain_result(STAT_OK));
			end
		endcase
	endtask

	// compare one taken result with the oldest owed one
	task automatic check_result();
		result_t got;
		result_t want;
		got.buffer_start   = m_axis_tdata[31:0];
		got.buffer_end     = m_axis_tdata[63:32];
		got.boundary_seq   = m_axis_tdata[95:64];
		got.boundary_tag   = m_axis_tdata[111:96];
		got.boundary_valid = m_axis_tuser[0];
		got.status         = status_t'(m_axis_tuser[2:1]);
		got.last_result    = m_axis_tlast;
		if (owed_wr == owed_rd) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: result with no request owing it: %s", $time, describe(got));
		end else begin
			want = owed_results[owed_rd % OWED_DEPTH];
			owed_rd++;
			if (got.buffer_start !== want.buffer_start || got.buffer_end !== want.buffer_end ||
					got.boundary_seq !== want.boundary_seq ||
					got.boundary_tag !== want.boundary_tag ||
					got.boundary_valid !== want.boundary_valid ||
					got.last_result !== want.last_result || got.status !== want.status) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: result mismatch, expected %s", $time, describe(want));
					$display("%0t:                  actual   %s", $time, describe(got));
				end
			end
		end
	endtask

	// results first, then register writes, then the new request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_buffer('0);
			owed_wr = 0;
			owed_rd = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (psel && penable && pwrite && pready && paddr == INIT_SEQ_ADDR)
				restart_buffer(pwdata);
			if (s_axis_tvalid && s_axis_tready)
				step_boundary_queue(s_axis_tdata);
		end
		bad_results <= mismatches;
		owed_count  <= owed_wr - owed_rd;
		view_start  <= buf_start;
		view_end    <= buf_end;
	end

endmodule

### tb/sv/tb_tcp_send_message_boundary_queue_unit.sv
// top of the boundary queue testbench: clock, reset, request and result streams,
// register writes and the verdict
// depends on tsmbq_pkg, tcp_send_message_boundary_queue_unit, tsmbq_boundary_checker
module tb_tcp_send_message_boundary_queue_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import tsmbq_pkg::*;

	localparam logic [PADDR_W-1:0] INIT_SEQ_ADDR = '0;
	localparam int unsigned ITEMS_PER_PHASE  = 15;
	localparam int unsigned SETTLE_CYCLES    = 80;
	localparam int unsigned LONG_HOLD_CYCLES = 300;
	// far above the slowest correct run: about 150 requests, a full ring walk
	// at most per request and every result stalled at the receiver
	localparam int unsigned CYCLE_LIMIT      = 1_000_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [OUT_USER_W-1:0] m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [PADDR_W-1:0]    paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	int unsigned           send_idle_pct = 0;
	int unsigned           recv_stall_pct = 0;
	logic                  hold_kick = 1'b0;
	int unsigned           cycle_cnt = 0;

	int unsigned           bad_results;
	int unsigned           owed_count;
	logic [SEQ_W-1:0]      view_start;
	logic [SEQ_W-1:0]      view_end;

	tcp_send_message_boundary_queue_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	tsmbq_boundary_checker #(
		.INIT_SEQ_ADDR (INIT_SEQ_ADDR)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.bad_results   (bad_results),
		.owed_count    (owed_count),
		.view_start    (view_start),
		.view_end      (view_end)
	);

	// 2 ns clock
	initial begin
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: random stalls, plus one long hold-off when kicked
	initial begin : result_sink
		logic kick_seen;
		int   held;
		kick_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_kick != kick_seen) begin
				kick_seen = hold_kick;
				m_axis_tready <= 1'b0;
				for (held = 0; held < LONG_HOLD_CYCLES; held++)
					@(posedge clk);
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_request(input opcode_t op,
			input logic [LEN_W-1:0] msg_len, input logic [TAG_W-1:0] msg_tag,
			input logic [SEQ_W-1:0] seg_start, input logic [LEN_W-1:0] seg_len,
			input logic [SEQ_W-1:0] acked);
		return IN_DATA_W'({acked, seg_len, seg_start, msg_tag, msg_len, op});
	endfunction

	// offer one request after a random gap and hold it until taken
	task automatic send_request(input logic [IN_DATA_W-1:0] req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= req;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop offering, wait for every owed result, then let the block settle
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (owed_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup and access cycle; the register takes the value at the access edge
	task automatic write_init_seq(input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= INIT_SEQ_ADDR;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly in-window queries and discards built from the current window
	task automatic send_random_request();
		logic [SEQ_W-1:0] span;
		logic [SEQ_W-1:0] room;
		logic [SEQ_W-1:0] seg_start;
		logic [SEQ_W-1:0] acked;
		logic [LEN_W-1:0] msg_len;
		logic [LEN_W-1:0] seg_len;
		int unsigned      pick;
		opcode_t          op;
		span      = view_end - view_start;
		msg_len   = 16'($urandom);
		seg_len   = 16'($urandom);
		seg_start = $urandom;
		acked     = $urandom;
		pick      = $urandom_range(0, 99);
		if (pick < 40) begin
			op = OP_ENQUEUE;
			case ($urandom_range(0, 9))
				0: msg_len = '0;
				1: msg_len = '1;
				default: msg_len = 16'($urandom_range(0, 3000));
			endcase
		end else if (pick < 70) begin
			op = OP_QUERY;
			if ($urandom_range(0, 9) != 0) begin
				seg_start = view_start + $urandom_range(0, span);
				room      = view_end - seg_start;
				seg_len   = 16'($urandom_range(0, (room > 32'd65535) ? 32'd65535 : room));
			end
		end else if (pick < 93) begin
			op = OP_DISCARD;
			if ($urandom_range(0, 9) != 0)
				acked = view_start + $urandom_range(0, span);
		end else begin
			op = OP_UNUSED;
		end
		send_request(pack_request(op, msg_len, 16'($urandom), seg_start, seg_len, acked));
	endtask

	initial begin : stimulus
		logic [SEQ_W-1:0] fill_end;
		int               ph;
		int               n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed requests from the reset window at zero
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'd0, 16'd0, $urandom));
		send_request(pack_request(OP_DISCARD, 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 32'd0));
		send_request(pack_request(OP_UNUSED, '1, '1, '1, '1, '1));
		send_request(pack_request(OP_ENQUEUE, 16'h0000, 16'h0000, $urandom, 16'($urandom),
			$urandom));
		send_request(pack_request(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, $urandom, 16'($urandom),
			$urandom));
		send_request(pack_request(OP_ENQUEUE, 16'h0001, 16'h1234, $urandom, 16'($urandom),
			$urandom));
		// boundary exactly at the segment start is skipped
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'd0, 16'd0, $urandom));
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'd0, 16'hFFFF,
			$urandom));
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'd1, 16'hFFFF,
			$urandom));
		// queries starting before the window and ending past it
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF, 16'd0,
			$urandom));
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'd65536, 16'd1,
			$urandom));
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'h8000_0000, 16'd0,
			$urandom));
		// discards outside the window, then partial and full pops
		send_request(pack_request(OP_DISCARD, 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 32'hFFFF_FFFF));
		send_request(pack_request(OP_DISCARD, 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 32'd65537));
		send_request(pack_request(OP_DISCARD, 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 32'd65535));
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'd65535, 16'd1,
			$urandom));
		send_request(pack_request(OP_DISCARD, 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 32'd65536));
		send_request(pack_request(OP_ENQUEUE, 16'h8000, 16'h5555, $urandom, 16'($urandom),
			$urandom));
		send_request(pack_request(OP_ENQUEUE, 16'hAAAA, 16'hAAAA, $urandom, 16'($urandom),
			$urandom));
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), 32'd65536, 16'hFFFF,
			$urandom));
		send_request(pack_request(OP_DISCARD, 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 32'd98304));
		send_request(pack_request(OP_DISCARD, 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), 32'd141994));
		drain_results();

		// fill the ring across the wrap of sequence space, overfill, then one full-ring query
		write_init_seq(32'hFFFF_C000);
		for (n = 0; n < QUEUE_DEPTH + 2; n++)
			send_request(pack_request(OP_ENQUEUE, 16'($urandom_range(0, 1000)), 16'($urandom),
				$urandom, 16'($urandom), $urandom));
		drain_results();
		fill_end = view_end;
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), view_start,
			16'(view_end - view_start), $urandom));
		send_request(pack_request(OP_DISCARD, 16'($urandom), 16'($urandom), $urandom,
			16'($urandom), fill_end));
		send_request(pack_request(OP_QUERY, 16'($urandom), 16'($urandom), fill_end, 16'd0,
			$urandom));
		drain_results();

		// random phases, each from a fresh starting sequence and idling pattern
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_init_seq(32'hFFFF_FFFF);
					send_idle_pct = 0;
					recv_stall_pct <= 0;
					hold_kick <= ~hold_kick;
				end
				1: begin
					write_init_seq(32'h7FFF_F000);
					send_idle_pct = 74;
					recv_stall_pct <= 0;
				end
				2: begin
					write_init_seq($urandom);
					send_idle_pct = 0;
					recv_stall_pct <= 74;
				end
				default: begin
					write_init_seq(32'h0000_0000);
					send_idle_pct = 11;
					recv_stall_pct <= 11;
				end
			endcase
			for (n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_request();
			drain_results();
		end

		if (bad_results == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
